@@ hdl/pcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcrc_pkg
// Types, register offsets, control fields and bit helpers for the
// programmable CRC register block.
// ----------------------------------------------------------------------------
package pcrc_pkg;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;

	localparam logic [11:0] OFS_DATA = 12'h000;
	localparam logic [11:0] OFS_POLY = 12'h004;
	localparam logic [11:0] OFS_CTRL = 12'h008;

	localparam logic [31:0] CTRL_TOT  = 32'hC000_0000;
	localparam logic [31:0] CTRL_TOTR = 32'h3000_0000;
	localparam logic [31:0] CTRL_INV  = 32'h0400_0000;
	localparam logic [31:0] CTRL_SEED = 32'h0200_0000;
	localparam logic [31:0] CTRL_WIDE = 32'h0100_0000;
	localparam logic [31:0] CTRL_MASK =
		CTRL_TOT | CTRL_TOTR | CTRL_INV | CTRL_SEED | CTRL_WIDE;

	localparam int CTRL_TOT_LSB  = 30;
	localparam int CTRL_INV_BIT  = 26;
	localparam int CTRL_SEED_BIT = 25;
	localparam int CTRL_WIDE_BIT = 24;

	localparam logic [1:0] TOT_NONE  = 2'd0;
	localparam logic [1:0] TOT_BITS  = 2'd1;
	localparam logic [1:0] TOT_BOTH  = 2'd2;
	localparam logic [1:0] TOT_BYTES = 2'd3;

	localparam logic [31:0] POLY_RESET = 32'h0000_1021;
	localparam logic [31:0] SEED_RESET = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_RESET  = 32'hFFFF_FFFF;
	localparam logic [31:0] MASK16     = 32'h0000_FFFF;

	typedef struct packed {
		logic        op;
		logic [11:0] offset;
		logic [1:0]  access_size;
		logic [31:0] wdata;
	} req_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic        bad_offset;
	} rsp_t;

	function automatic logic [31:0] swap_bytes(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [31:0] reverse_in_bytes(input logic [31:0] v);
		logic [31:0] r;
		r = ((v & 32'h0F0F_0F0F) << 4) | ((v >> 4) & 32'h0F0F_0F0F);
		r = ((r & 32'h3333_3333) << 2) | ((r >> 2) & 32'h3333_3333);
		r = ((r & 32'h5555_5555) << 1) | ((r >> 1) & 32'h5555_5555);
		return r;
	endfunction

	function automatic logic [31:0] transpose(input logic [31:0] v,
			input logic [31:0] ctrl);
		logic [31:0] r;
		case (ctrl[CTRL_TOT_LSB +: 2])
			TOT_BITS:  r = reverse_in_bytes(v);
			TOT_BOTH:  r = reverse_in_bytes(swap_bytes(v));
			TOT_BYTES: r = swap_bytes(v);
			default:   r = v;
		endcase
		if (!ctrl[CTRL_WIDE_BIT]) begin
			r = r & MASK16;
		end
		return r;
	endfunction

	// Shift all 32 data bits MSB first through the CRC register.
	function automatic logic [31:0] crc_feed(input logic [31:0] crc_in,
			input logic [31:0] poly_in, input logic [31:0] din,
			input logic wide);
		logic [31:0] mask;
		logic [31:0] crc;
		logic [31:0] poly;
		logic [4:0]  top;
		logic        fb;
		mask = wide ? 32'hFFFF_FFFF : MASK16;
		top  = wide ? 5'd31 : 5'd15;
		poly = poly_in & mask;
		crc  = crc_in & mask;
		for (int i = 0; i < 32; i++) begin
			fb  = crc[top] ^ din[5'(31 - i)];
			crc = (crc << 1) & mask;
			if (fb) begin
				crc = crc ^ poly;
			end
		end
		return crc;
	endfunction

endpackage

@@ hdl/programmable_crc_unit_registers_core.sv @@
// ----------------------------------------------------------------------------
// programmable_crc_unit_registers_core
// Register view of a programmable CRC-16/CRC-32 unit: data, polynomial and
// control words, one bus request per item, narrow accesses by read-merge-write.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  req     | in        | req_valid / req_stall  | req_t  (op, offset, size, wdata)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_t  (rdata, bad_offset)
//
//  One request per cycle while the response is not stalled; each passes the
//  request register, then the full 32-bit CRC network into the response register
//  and the state registers at the same edge.
//  Reset loads polynomial 0x1021, seed and CRC all ones, control zero.
//  A stalled response holds; a held request stalls req while the response
//  register is full and stalled.
module programmable_crc_unit_registers_core
	import pcrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic        valid_s1;
	req_t        req_s1;
	logic        out_free;
	logic        fire_s1;

	logic [31:0] ctrl_q;
	logic [31:0] poly_q;
	logic [31:0] seed_q;
	logic [31:0] crc_q;

	logic        narrow;
	logic [11:0] addr;
	logic        known;
	logic [31:0] full;
	logic [4:0]  sh;
	logic [31:0] wmask;
	logic [31:0] merged;
	logic [31:0] wval;
	logic [31:0] tval;
	logic [31:0] rd_val;
	logic        do_write;
	logic [31:0] ctrl_new;

	assign out_free  = !rsp_valid || !rsp_stall;
	assign fire_s1   = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	// Decode and read the addressed word.
	always_comb begin
		narrow = (req_s1.access_size == SIZE_BYTE) || (req_s1.access_size == SIZE_HALF);
		addr   = narrow ? {req_s1.offset[11:2], 2'b00} : req_s1.offset;
		known  = (addr == OFS_DATA) || (addr == OFS_POLY) || (addr == OFS_CTRL);
		case (addr)
			OFS_DATA: begin
				if (ctrl_q[CTRL_SEED_BIT]) begin
					full = seed_q;
				end else begin
					full = ctrl_q[CTRL_INV_BIT] ? ~crc_q : crc_q;
				end
			end
			OFS_POLY: full = poly_q;
			OFS_CTRL: full = ctrl_q;
			default:  full = '0;
		endcase
		sh     = {req_s1.offset[1:0], 3'b000};
		wmask  = (req_s1.access_size == SIZE_BYTE) ? 32'h0000_00FF : MASK16;
		merged = (full & ~(wmask << sh)) | ((req_s1.wdata & wmask) << sh);
		wval   = narrow ? merged : req_s1.wdata;
		tval   = transpose(wval, ctrl_q);
		ctrl_new = wval & CTRL_MASK;
		do_write = fire_s1 && (req_s1.op == OP_WRITE) && known;

		if (req_s1.op == OP_READ) begin
			case (req_s1.access_size)
				SIZE_BYTE: rd_val = (full >> sh) & 32'h0000_00FF;
				SIZE_HALF: rd_val = req_s1.offset[1] ? (full >> 16) : (full & MASK16);
				default:   rd_val = full;
			endcase
		end else begin
			rd_val = '0;
		end
	end

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (out_free) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp.rdata      <= known ? rd_val : '0;
			rsp.bad_offset <= !known;
		end
	end

	// Register file and CRC state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			poly_q <= POLY_RESET;
			seed_q <= SEED_RESET;
			crc_q  <= CRC_RESET;
		end else if (do_write) begin
			case (addr)
				OFS_DATA: begin
					if (ctrl_q[CTRL_SEED_BIT]) begin
						seed_q <= tval;
						crc_q  <= tval;
					end else begin
						crc_q <= crc_feed(crc_q, poly_q, tval, ctrl_q[CTRL_WIDE_BIT]);
					end
				end
				OFS_POLY: poly_q <= wval;
				OFS_CTRL: begin
					ctrl_q <= ctrl_new;
					// reload the running CRC from the seed
					if (ctrl_new[CTRL_SEED_BIT]) begin
						crc_q <= seed_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Checks.
	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1)
		else $error("request stalled with empty request register");

	a_ctrl_reserved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_q & ~CTRL_MASK) == 32'h0)
		else $error("reserved control bits set");

	a_bad_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.bad_offset) |-> (rsp.rdata == 32'h0))
		else $error("bad offset returned nonzero data");

	a_crc16_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(do_write && (addr == OFS_DATA) && !ctrl_q[CTRL_SEED_BIT]
			&& !ctrl_q[CTRL_WIDE_BIT]) |=> (crc_q[31:16] == 16'h0))
		else $error("16-bit CRC left upper bits set");

endmodule
